@@ rtl/first_fit_block_chain_allocator_defines.svh @@
// assertion macros for the block chain allocator
`ifndef FIRST_FIT_BLOCK_CHAIN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_CHAIN_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFBCA_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define FFBCA_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define FFBCA_ASSERT_SAME(lbl, cond, prop)
`define FFBCA_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

@@ rtl/ffbca_pkg.sv @@
// shared types, codes and constants of the block chain allocator
package ffbca_pkg;

    localparam int ARENA_PARAGRAPHS_DEF = 4096;
    localparam int FREE_SUM_W = 12;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_FREE     = 3'd1;
    localparam logic [2:0] CMD_SIZE     = 3'd2;
    localparam logic [2:0] CMD_COALESCE = 3'd3;
    localparam logic [2:0] CMD_REPORT   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_NULL,
        RES_MISS,
        RES_ALLOC,
        RES_SIZE,
        RES_COAL,
        RES_REPORT
    } res_kind_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ALLOC,
        WR_REMAIN,
        WR_FREE,
        WR_MERGE
    } wr_kind_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] byte_count;
        logic        take_largest;
        logic [15:0] owner;
        logic [15:0] block_paragraph;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_paragraph;
        logic [12:0] size_paragraphs;
        logic        merged_any;
        logic [15:0] free_bytes;
        logic [15:0] largest_free_bytes;
    } res_t;

    typedef struct packed {
        logic      load;
        logic      clr_walk;
        logic      rd;
        logic      step;
        logic      acc;
        logic      set_need;
        logic      cap;
        logic      prev_load;
        wr_kind_t  wr;
        logic      fin;
        res_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       take;
        logic       zero_bytes;
        logic       null_par;
        logic       adv_ok;
        logic       fit;
        logic       split;
        logic       hit;
        logic       pair_free;
        logic       pass_merged;
    } dp_stat_t;

endpackage

@@ rtl/ffbca_ram.sv @@
// generic single write port ram with registered read
module ffbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/ffbca_dp.sv @@
// datapath: request registers, chain walk registers, header store and results
module ffbca_dp #(
    parameter int ARENA_PARAGRAPHS = ffbca_pkg::ARENA_PARAGRAPHS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  ffbca_pkg::req_t    request,
    input  ffbca_pkg::dp_cmd_t cmd,
    output ffbca_pkg::dp_stat_t stat,
    output logic               done,
    output ffbca_pkg::res_t    result
);
    import ffbca_pkg::*;

    localparam int OW  = $clog2(ARENA_PARAGRAPHS);
    localparam int SW  = $clog2(ARENA_PARAGRAPHS + 1);
    localparam int NW  = (SW + 1 > 13) ? SW + 1 : 13;
    localparam int HW  = 1 + 16 + SW;
    localparam int AW  = ((OW > SW) ? OW : SW) + 1;
    localparam int PW  = NW + 1;

    logic [15:0]          base_reg;
    logic [2:0]           cmd_reg;
    logic                 take_reg;
    logic [15:0]          bytes_reg;
    logic [15:0]          owner_reg;
    logic [15:0]          bpar_reg;
    logic [15:0]          target_reg;
    logic [OW-1:0]        off_reg;
    logic [OW-1:0]        prev_off_reg;
    logic [15:0]          prev_owner_reg;
    logic [SW-1:0]        prev_size_reg;
    logic                 cur_last_reg;
    logic [SW-1:0]        cur_size_reg;
    logic [NW-1:0]        need_reg;
    logic [FREE_SUM_W-1:0] sum_reg;
    logic [SW-1:0]        largest_reg;
    logic                 merged_reg;
    logic                 pass_reg;
    logic                 zero_sel_reg;
    logic                 hdr0_wr_reg;
    logic                 done_reg;
    res_t                 res_reg;
    res_t                 res_next;

    logic [HW-1:0]        ram_q;
    logic                 we;
    logic [OW-1:0]        waddr;
    logic [HW-1:0]        wdata;
    logic                 hdr_last;
    logic [15:0]          hdr_owner;
    logic [SW-1:0]        hdr_size;
    logic [AW-1:0]        next_off;
    logic [PW-1:0]        split_end;
    logic [SW-1:0]        dec_size;
    logic [SW-1:0]        merge_size;
    logic                 use_rst;

    ffbca_ram #(.WIDTH(HW), .DEPTH(ARENA_PARAGRAPHS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (off_reg),
        .rdata (ram_q)
    );

    // entry 0 reads as one free block over the whole arena until first written
    assign use_rst   = zero_sel_reg && !hdr0_wr_reg;
    assign hdr_last  = use_rst ? 1'b1 : ram_q[HW-1];
    assign hdr_owner = use_rst ? 16'd0 : ram_q[HW-2 -: 16];
    assign hdr_size  = use_rst ? SW'(ARENA_PARAGRAPHS) : ram_q[SW-1:0];

    assign next_off   = AW'(off_reg) + AW'(hdr_size);
    assign split_end  = PW'(off_reg) + PW'(need_reg);
    assign dec_size   = hdr_size - SW'(1);
    assign merge_size = prev_size_reg + hdr_size;

    assign stat.command     = cmd_reg;
    assign stat.take        = take_reg;
    assign stat.zero_bytes  = (bytes_reg == 16'd0);
    assign stat.null_par    = (bpar_reg == 16'd0);
    assign stat.adv_ok      = !hdr_last && (hdr_size != '0)
                              && (next_off < AW'(ARENA_PARAGRAPHS));
    assign stat.fit         = (hdr_owner == 16'd0) && (NW'(hdr_size) >= need_reg);
    assign stat.split       = (NW'(hdr_size) > need_reg)
                              && (split_end < PW'(ARENA_PARAGRAPHS));
    assign stat.hit         = ((base_reg + 16'(off_reg)) == target_reg);
    assign stat.pair_free   = (prev_owner_reg == 16'd0) && (hdr_owner == 16'd0);
    assign stat.pass_merged = pass_reg;

    always_comb
    begin
        we    = 1'b1;
        waddr = off_reg;
        wdata = {hdr_last, hdr_owner, hdr_size};
        unique case (cmd.wr)
            WR_ALLOC:
            begin
                wdata = {(stat.split ? 1'b0 : hdr_last), owner_reg, SW'(need_reg)};
            end
            WR_REMAIN:
            begin
                waddr = OW'(split_end);
                wdata = {cur_last_reg, 16'd0, cur_size_reg - SW'(need_reg)};
            end
            WR_FREE:
            begin
                wdata = {hdr_last, 16'd0, hdr_size};
            end
            WR_MERGE:
            begin
                waddr = prev_off_reg;
                wdata = {hdr_last, prev_owner_reg, merge_size};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_next = '0;
        unique case (cmd.kind)
            RES_NULL:   res_next.status = ST_NULL;
            RES_MISS:   res_next.status = ST_MISS;
            RES_ALLOC:  res_next.data_paragraph = base_reg + 16'(off_reg) + 16'd1;
            RES_SIZE:   res_next.size_paragraphs = 13'(hdr_size);
            RES_COAL:   res_next.merged_any = merged_reg;
            RES_REPORT:
            begin
                res_next.free_bytes         = {sum_reg, 4'd0};
                res_next.largest_free_bytes = {12'(largest_reg), 4'd0};
            end
            default:    res_next.status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            hdr0_wr_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (we && (waddr == '0))
            begin
                hdr0_wr_reg <= 1'b1;
            end
            done_reg <= cmd.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            res_reg <= res_next;
        end
        if (cmd.rd)
        begin
            zero_sel_reg <= (off_reg == '0);
        end
        if (cmd.load)
        begin
            cmd_reg     <= request.command;
            take_reg    <= request.take_largest;
            bytes_reg   <= request.byte_count;
            owner_reg   <= request.owner;
            bpar_reg    <= request.block_paragraph;
            target_reg  <= request.block_paragraph - 16'd1;
            sum_reg     <= '0;
            largest_reg <= '0;
            merged_reg  <= 1'b0;
        end
        if (cmd.clr_walk)
        begin
            off_reg <= '0;
        end
        if (cmd.step)
        begin
            off_reg <= OW'(next_off);
        end
        if (cmd.set_need)
        begin
            if (take_reg)
            begin
                need_reg <= NW'(largest_reg) + NW'(1);
            end
            else
            begin
                need_reg <= NW'(bytes_reg[15:4]) + NW'(1) + NW'(|bytes_reg[3:0]);
            end
        end
        if (cmd.acc && (hdr_owner == 16'd0) && (hdr_size != '0))
        begin
            sum_reg <= sum_reg + FREE_SUM_W'(dec_size);
            if (dec_size > largest_reg)
            begin
                largest_reg <= dec_size;
            end
        end
        if (cmd.cap)
        begin
            cur_last_reg <= hdr_last;
            cur_size_reg <= hdr_size;
        end
        if (cmd.prev_load)
        begin
            prev_off_reg   <= off_reg;
            prev_owner_reg <= hdr_owner;
            prev_size_reg  <= hdr_size;
        end
        else if (cmd.clr_walk)
        begin
            prev_off_reg <= '0;
        end
        if (cmd.clr_walk)
        begin
            pass_reg <= 1'b0;
        end
        else if (cmd.wr == WR_MERGE)
        begin
            pass_reg <= 1'b1;
        end
        if (cmd.wr == WR_MERGE)
        begin
            prev_size_reg <= merge_size;
            merged_reg    <= 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

@@ rtl/ffbca_ctrl.sv @@
// controller: sequences the chain walks for each request
module ffbca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ffbca_pkg::dp_stat_t stat,
    output ffbca_pkg::dp_cmd_t  cmd,
    output logic                busy
);
    import ffbca_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_EV = 4'd3;
    localparam logic [3:0] S_NEED    = 4'd4;
    localparam logic [3:0] S_AL_RD   = 4'd5;
    localparam logic [3:0] S_AL_EV   = 4'd6;
    localparam logic [3:0] S_AL_WR2  = 4'd7;
    localparam logic [3:0] S_FD_RD   = 4'd8;
    localparam logic [3:0] S_FD_EV   = 4'd9;
    localparam logic [3:0] S_CO_RD0  = 4'd10;
    localparam logic [3:0] S_CO_EV0  = 4'd11;
    localparam logic [3:0] S_CO_RD   = 4'd12;
    localparam logic [3:0] S_CO_EV   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.wr     = WR_NONE;
        cmd.kind   = RES_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.clr_walk = 1'b1;
                priority if (stat.command == CMD_ALLOC)
                begin
                    priority if (!stat.take && stat.zero_bytes)
                    begin
                        cmd.fin    = 1'b1;
                        cmd.kind   = RES_NULL;
                        state_next = S_IDLE;
                    end
                    else if (stat.take)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        cmd.set_need = 1'b1;
                        state_next   = S_AL_RD;
                    end
                end
                else if (stat.command == CMD_FREE || stat.command == CMD_SIZE)
                begin
                    if (stat.null_par)
                    begin
                        cmd.fin    = 1'b1;
                        cmd.kind   = RES_NULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FD_RD;
                    end
                end
                else if (stat.command == CMD_COALESCE)
                begin
                    state_next = S_CO_RD0;
                end
                else if (stat.command == CMD_REPORT)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.acc = 1'b1;
                if (stat.adv_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_NEED;
                end
            end
            S_NEED:
            begin
                if (stat.command == CMD_REPORT)
                begin
                    cmd.fin    = 1'b1;
                    cmd.kind   = RES_REPORT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.set_need = 1'b1;
                    cmd.clr_walk = 1'b1;
                    state_next   = S_AL_RD;
                end
            end
            S_AL_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_AL_EV;
            end
            S_AL_EV:
            begin
                cmd.cap = 1'b1;
                priority if (stat.fit)
                begin
                    cmd.wr = WR_ALLOC;
                    if (stat.split)
                    begin
                        state_next = S_AL_WR2;
                    end
                    else
                    begin
                        cmd.fin    = 1'b1;
                        cmd.kind   = RES_ALLOC;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.adv_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_AL_RD;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.kind   = RES_MISS;
                    state_next = S_IDLE;
                end
            end
            S_AL_WR2:
            begin
                cmd.wr     = WR_REMAIN;
                cmd.fin    = 1'b1;
                cmd.kind   = RES_ALLOC;
                state_next = S_IDLE;
            end
            S_FD_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_FD_EV;
            end
            S_FD_EV:
            begin
                priority if (stat.hit)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                    if (stat.command == CMD_FREE)
                    begin
                        cmd.wr = WR_FREE;
                    end
                    else
                    begin
                        cmd.kind = RES_SIZE;
                    end
                end
                else if (stat.adv_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_FD_RD;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.kind   = RES_MISS;
                    state_next = S_IDLE;
                end
            end
            S_CO_RD0:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CO_EV0;
            end
            S_CO_EV0:
            begin
                cmd.prev_load = 1'b1;
                priority if (stat.adv_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CO_RD;
                end
                else if (stat.pass_merged)
                begin
                    cmd.clr_walk = 1'b1;
                    state_next   = S_CO_RD0;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.kind   = RES_COAL;
                    state_next = S_IDLE;
                end
            end
            S_CO_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CO_EV;
            end
            S_CO_EV:
            begin
                if (stat.pair_free)
                begin
                    cmd.wr = WR_MERGE;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                end
                priority if (stat.adv_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CO_RD;
                end
                else if (stat.pass_merged || stat.pair_free)
                begin
                    cmd.clr_walk = 1'b1;
                    state_next   = S_CO_RD0;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.kind   = RES_COAL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule

@@ rtl/first_fit_block_chain_allocator.sv @@
// top level of the first-fit block chain allocator
// A request is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. Every
// request except those answered at dispatch (zero-byte alloc, null-paragraph
// free or size, unknown command) walks the header chain from the arena start,
// reading each block header and then evaluating it; a splitting alloc adds a
// remainder header write, take-largest alloc is preceded by a full chain scan,
// report is one such scan, and coalesce repeats passes until one merges none.
// No clearing pass is needed after reset.
`include "first_fit_block_chain_allocator_defines.svh"
module first_fit_block_chain_allocator #(
    parameter int ARENA_PARAGRAPHS = ffbca_pkg::ARENA_PARAGRAPHS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffbca_pkg::req_t request,
    output logic            done,
    output ffbca_pkg::res_t result,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata
);
    import ffbca_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffbca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffbca_dp #(.ARENA_PARAGRAPHS(ARENA_PARAGRAPHS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    `FFBCA_ASSERT_SAME(a_done_when_idle, done, !busy)
    `FFBCA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !done)
    `FFBCA_ASSERT_NEXT(a_single_result, done, !done)
endmodule
